// ===== sv/ias_pkg.sv =====
// ----------------------------------------------------------------------------
// ias_pkg: shared types and constants of the alarm suppressor
// Widths of the configuration fields, result codes and sequencer states.
// ----------------------------------------------------------------------------
package ias_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int STAMP_BITS_DEF = 48;

    // configuration fields
    localparam int THR_BITS      = 17;
    localparam int HOLD_BITS     = 17;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 17;

    // hold time scaling, seconds to milliseconds
    localparam int MS_PER_SEC   = 1000;
    localparam int HOLD_MS_BITS = HOLD_BITS + 10;

    // threshold scale, Q1.16
    localparam int IOU_FRAC_BITS = 16;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_ENABLE = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_THR    = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD   = CFG_IDX_BITS'(2);

    typedef enum logic [2:0] {
        CAUSE_BYPASS     = 3'd0,
        CAUSE_FIRST      = 3'd1,
        CAUSE_LOW_OVL    = 3'd2,
        CAUSE_HOLD_EXP   = 3'd3,
        CAUSE_SUPPRESSED = 3'd4,
        CAUSE_ZERO_UNION = 3'd5
    } t_cause;

    typedef enum logic [3:0] {
        S_IDLE,
        S_OVL,
        S_INTER,
        S_ANEW,
        S_AOLD,
        S_TLO,
        S_THI,
        S_DECIDE,
        S_RESULT
    } t_state;

endpackage

// ===== sv/ias_box_if.sv =====
// ----------------------------------------------------------------------------
// ias_box_if: detection box request channel
// Valid/ready channel carrying one box and its time stamp.
// ----------------------------------------------------------------------------
interface ias_box_if #(
    parameter int COORD_BITS = 16,
    parameter int STAMP_BITS = 48
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] box_x;
    logic [COORD_BITS-1:0] box_y;
    logic [COORD_BITS-1:0] box_width;
    logic [COORD_BITS-1:0] box_height;
    logic [STAMP_BITS-1:0] stamp_ms;

    modport source (
        output valid, box_x, box_y, box_width, box_height, stamp_ms,
        input  ready
    );
    modport sink (
        input  valid, box_x, box_y, box_width, box_height, stamp_ms,
        output ready
    );
endinterface

// ===== sv/ias_res_if.sv =====
// ----------------------------------------------------------------------------
// ias_res_if: decision result channel
// Valid/ready channel carrying the report flag and its cause code.
// ----------------------------------------------------------------------------
interface ias_res_if;
    logic       valid;
    logic       ready;
    logic       report;
    logic [2:0] cause;

    modport source (
        output valid, report, cause,
        input  ready
    );
    modport sink (
        input  valid, report, cause,
        output ready
    );
endinterface

// ===== sv/ias_cfg_if.sv =====
// ----------------------------------------------------------------------------
// ias_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface ias_cfg_if;
    import ias_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ===== sv/iou_alarm_suppressor.sv =====
// ----------------------------------------------------------------------------
// iou_alarm_suppressor: repeated alarm suppression by box overlap and hold time
// Sequence: a box request steps through S_OVL, S_INTER, S_ANEW, S_AOLD,
//   S_TLO, S_THI, S_DECIDE and S_RESULT (bypass or empty history go straight
//   to S_RESULT), one box in flight; the shared 17x17 multiplier sets the steps.
//   The next box is taken while the previous result waits at the output.
// Reset: synchronous active low; clears config, history, enable tracking
//   and the output valid.
// ----------------------------------------------------------------------------
module iou_alarm_suppressor #(
    parameter int COORD_BITS = ias_pkg::COORD_BITS_DEF,
    parameter int STAMP_BITS = ias_pkg::STAMP_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ias_cfg_if.sink   i_cfg,
    ias_box_if.sink   i_box,
    ias_res_if.source o_res
);
    import ias_pkg::*;

    // multiplier operand width: threshold and hold fields are the widest
    localparam int MW  = THR_BITS;
    localparam int PW  = 2 * MW;
    localparam int CE  = COORD_BITS + 1;          // coordinate plus extent
    localparam int AW  = 2 * COORD_BITS;          // one area
    localparam int UW  = 2 * COORD_BITS + 1;      // union of two areas
    localparam int RB  = 2 * COORD_BITS + THR_BITS + 1;  // compare width
    localparam int LW  = AW + IOU_FRAC_BITS;      // scaled intersection

    // configuration registers
    logic                  r_enable, n_enable;
    logic [THR_BITS-1:0]   r_thr, n_thr;
    logic [HOLD_BITS-1:0]  r_hold, n_hold;

    // history of the last reported box
    logic                  r_enable_seen, n_enable_seen;
    logic [COORD_BITS-1:0] r_lx, n_lx, r_ly, n_ly, r_lw, n_lw, r_lh, n_lh;
    logic [STAMP_BITS-1:0] r_lt, n_lt;

    // current box
    logic [COORD_BITS-1:0] r_bx, n_bx, r_by, n_by, r_bw, n_bw, r_bh, n_bh;
    logic [STAMP_BITS-1:0] r_bt, n_bt;

    // working registers
    logic [COORD_BITS-1:0] r_dx, n_dx, r_dy, n_dy;
    logic [AW-1:0]         r_inter, n_inter;
    logic [UW-1:0]         r_union, n_union;
    logic [RB-1:0]         r_rhs, n_rhs;
    logic [HOLD_MS_BITS-1:0] r_hold_ms, n_hold_ms;
    t_cause                r_cause, n_cause;

    // control
    t_state                r_state, n_state;
    logic                  r_out_valid, n_out_valid;
    t_cause                r_out_cause, n_out_cause;

    // shared multiplier
    logic [MW-1:0]         mul_a, mul_b;
    logic [PW-1:0]         mul_p;

    // overlap helpers
    logic [CE-1:0]         left_x, right_x, top_y, bottom_y;
    logic [CE-1:0]         end_lx, end_bx, end_ly, end_by;
    logic [LW-1:0]         inter_scaled;
    logic [STAMP_BITS-1:0] elapsed;
    logic                  box_acc, en_chg, hist_empty;

    assign mul_p = PW'(mul_a) * PW'(mul_b);

    assign i_cfg.ready  = 1'b1;
    assign i_box.ready  = (r_state == S_IDLE);
    assign box_acc      = i_box.valid && (r_state == S_IDLE);
    assign o_res.valid  = r_out_valid;
    assign o_res.cause  = r_out_cause;
    assign o_res.report = (r_out_cause != CAUSE_SUPPRESSED);

    // overlap extents of stored and current box
    assign end_lx   = CE'(r_lx) + CE'(r_lw);
    assign end_bx   = CE'(r_bx) + CE'(r_bw);
    assign end_ly   = CE'(r_ly) + CE'(r_lh);
    assign end_by   = CE'(r_by) + CE'(r_bh);
    assign left_x   = (r_lx > r_bx) ? CE'(r_lx) : CE'(r_bx);
    assign top_y    = (r_ly > r_by) ? CE'(r_ly) : CE'(r_by);
    assign right_x  = (end_lx < end_bx) ? end_lx : end_bx;
    assign bottom_y = (end_ly < end_by) ? end_ly : end_by;

    assign inter_scaled = {r_inter, {IOU_FRAC_BITS{1'b0}}};
    // older stamp than the stored one counts as no time elapsed
    assign elapsed      = (r_bt >= r_lt) ? (r_bt - r_lt) : '0;

    // enable change seen at request time clears the history first
    assign en_chg     = (r_enable != r_enable_seen);
    assign hist_empty = en_chg || ((r_lw == '0) && (r_lh == '0));

    always_comb begin
        n_enable      = r_enable;
        n_thr         = r_thr;
        n_hold        = r_hold;
        n_enable_seen = r_enable_seen;
        n_lx          = r_lx;
        n_ly          = r_ly;
        n_lw          = r_lw;
        n_lh          = r_lh;
        n_lt          = r_lt;
        n_bx          = r_bx;
        n_by          = r_by;
        n_bw          = r_bw;
        n_bh          = r_bh;
        n_bt          = r_bt;
        n_dx          = r_dx;
        n_dy          = r_dy;
        n_inter       = r_inter;
        n_union       = r_union;
        n_rhs         = r_rhs;
        n_hold_ms     = r_hold_ms;
        n_cause       = r_cause;
        n_state       = r_state;
        n_out_valid   = r_out_valid;
        n_out_cause   = r_out_cause;
        mul_a         = '0;
        mul_b         = '0;

        // register writes, ignored beyond the register list
        if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_ENABLE: n_enable = i_cfg.data[0];
                CFG_THR:    n_thr    = i_cfg.data[THR_BITS-1:0];
                CFG_HOLD:   n_hold   = i_cfg.data[HOLD_BITS-1:0];
                default:    ;
            endcase
        end

        // result taken downstream
        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (box_acc) begin
                    n_bx = i_box.box_x;
                    n_by = i_box.box_y;
                    n_bw = i_box.box_width;
                    n_bh = i_box.box_height;
                    n_bt = i_box.stamp_ms;
                    n_enable_seen = r_enable;
                    if (en_chg) begin
                        n_lx = '0;
                        n_ly = '0;
                        n_lw = '0;
                        n_lh = '0;
                        n_lt = '0;
                    end
                    if (!r_enable || (r_thr == '0)) begin
                        n_cause = CAUSE_BYPASS;
                        n_state = S_RESULT;
                    end else if (hist_empty) begin
                        n_cause = CAUSE_FIRST;
                        n_lx    = i_box.box_x;
                        n_ly    = i_box.box_y;
                        n_lw    = i_box.box_width;
                        n_lh    = i_box.box_height;
                        n_lt    = i_box.stamp_ms;
                        n_state = S_RESULT;
                    end else begin
                        n_state = S_OVL;
                    end
                end
            end
            S_OVL: begin
                // side lengths of the intersection, zero when disjoint
                n_dx = (left_x < right_x) ? COORD_BITS'(right_x - left_x) : '0;
                n_dy = (top_y < bottom_y) ? COORD_BITS'(bottom_y - top_y) : '0;
                // hold time in ms while the multiplier is free
                mul_a     = MW'(r_hold);
                mul_b     = MW'(MS_PER_SEC);
                n_hold_ms = mul_p[HOLD_MS_BITS-1:0];
                n_state   = S_INTER;
            end
            S_INTER: begin
                mul_a   = MW'(r_dx);
                mul_b   = MW'(r_dy);
                n_inter = mul_p[AW-1:0];
                n_state = S_ANEW;
            end
            S_ANEW: begin
                mul_a   = MW'(r_bw);
                mul_b   = MW'(r_bh);
                n_union = UW'(mul_p[AW-1:0]);
                n_state = S_AOLD;
            end
            S_AOLD: begin
                // union = new area + stored area - intersection
                mul_a   = MW'(r_lw);
                mul_b   = MW'(r_lh);
                n_union = r_union + UW'(mul_p[AW-1:0]) - UW'(r_inter);
                n_state = S_TLO;
            end
            S_TLO: begin
                // threshold times union, low slice
                mul_a   = r_thr;
                mul_b   = MW'(r_union[COORD_BITS:0]);
                n_rhs   = RB'(mul_p);
                n_state = S_THI;
            end
            S_THI: begin
                // high slice, shifted into place
                mul_a   = r_thr;
                mul_b   = MW'(r_union[UW-1:COORD_BITS+1]);
                n_rhs   = r_rhs + (RB'(mul_p) << (COORD_BITS + 1));
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_state = S_RESULT;
                if (r_union == '0) begin
                    n_cause = CAUSE_ZERO_UNION;
                end else if (RB'(inter_scaled) >= r_rhs) begin
                    if (elapsed >= STAMP_BITS'(r_hold_ms)) begin
                        n_cause = CAUSE_HOLD_EXP;
                    end else begin
                        n_cause = CAUSE_SUPPRESSED;
                    end
                end else begin
                    n_cause = CAUSE_LOW_OVL;
                end
                // every outcome except suppression replaces the history
                if (!((r_union != '0) && (RB'(inter_scaled) >= r_rhs)
                      && (elapsed < STAMP_BITS'(r_hold_ms)))) begin
                    n_lx = r_bx;
                    n_ly = r_by;
                    n_lw = r_bw;
                    n_lh = r_bh;
                    n_lt = r_bt;
                end
            end
            S_RESULT: begin
                // wait for the output register to free up
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_out_cause = r_cause;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and history registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_enable      <= 1'b0;
            r_thr         <= '0;
            r_hold        <= '0;
            r_enable_seen <= 1'b0;
            r_lx          <= '0;
            r_ly          <= '0;
            r_lw          <= '0;
            r_lh          <= '0;
            r_lt          <= '0;
        end else begin
            r_state       <= n_state;
            r_out_valid   <= n_out_valid;
            r_enable      <= n_enable;
            r_thr         <= n_thr;
            r_hold        <= n_hold;
            r_enable_seen <= n_enable_seen;
            r_lx          <= n_lx;
            r_ly          <= n_ly;
            r_lw          <= n_lw;
            r_lh          <= n_lh;
            r_lt          <= n_lt;
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        r_bx        <= n_bx;
        r_by        <= n_by;
        r_bw        <= n_bw;
        r_bh        <= n_bh;
        r_bt        <= n_bt;
        r_dx        <= n_dx;
        r_dy        <= n_dy;
        r_inter     <= n_inter;
        r_union     <= n_union;
        r_rhs       <= n_rhs;
        r_hold_ms   <= n_hold_ms;
        r_cause     <= n_cause;
        r_out_cause <= n_out_cause;
    end

endmodule

// ===== test/tb_iou_alarm_suppressor.sv =====
// ----------------------------------------------------------------------------
// tb_iou_alarm_suppressor: self-checking bench for the alarm suppressor
// Drives detection boxes and register writes over valid/ready channels with
// random idle gaps on both sides, predicts each report/cause decision from a
// behavioral copy of the suppressor state and checks every result in order.
// ----------------------------------------------------------------------------
module tb_iou_alarm_suppressor;
    timeunit 1ns;
    timeprecision 1ps;

    import ias_pkg::*;

    localparam int COORD_W = COORD_BITS_DEF;
    localparam int STAMP_W = STAMP_BITS_DEF;

    // index 3 has no register behind it, writes must be harmless
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = CFG_IDX_BITS'(3);

    localparam int RANDOM_BOXES = 1500;
    localparam int MAX_GAP      = 11;
    localparam int MAX_REPORTED = 10;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] width;
        logic [COORD_W-1:0] height;
        logic [STAMP_W-1:0] stamp;
    } t_alarm_box;

    typedef struct {
        logic   report;
        t_cause cause;
    } t_alarm_decision;

    // ------------------------------------------------------------------------
    // decision scoreboard: mirrors registers and history, queues predictions
    // ------------------------------------------------------------------------
    class alarm_scoreboard;
        bit                     en;
        bit                     en_seen;
        logic [THR_BITS-1:0]    thr;
        logic [HOLD_BITS-1:0]   hold_sec;
        t_alarm_box             last_box;
        t_alarm_decision        pending[$];
        int unsigned            fail_count;

        function new();
            en         = 1'b0;
            en_seen    = 1'b0;
            thr        = '0;
            hold_sec   = '0;
            last_box   = '0;
            fail_count = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_ENABLE: en       = data[0];
                CFG_THR:    thr      = data[THR_BITS-1:0];
                CFG_HOLD:   hold_sec = data[HOLD_BITS-1:0];
                default: ;
            endcase
        endfunction

        // accepted box request: work out its decision and update the history
        function void note_box(t_alarm_box b);
            longint unsigned ox, oy, ow, oh, nx, ny, nw, nh;
            longint unsigned left, top, right, bottom, overlap, merged;
            longint unsigned elapsed, hold_ms;
            t_alarm_decision d;
            if (en != en_seen) begin
                en_seen  = en;
                last_box = '0;
            end
            d.report = 1'b1;
            if (!en || thr == 0) begin
                d.cause = CAUSE_BYPASS;
            end else if (last_box.width == 0 && last_box.height == 0) begin
                d.cause  = CAUSE_FIRST;
                last_box = b;
            end else begin
                ox = last_box.x;
                oy = last_box.y;
                ow = last_box.width;
                oh = last_box.height;
                nx = b.x;
                ny = b.y;
                nw = b.width;
                nh = b.height;
                left    = (ox > nx) ? ox : nx;
                top     = (oy > ny) ? oy : ny;
                right   = (ox + ow < nx + nw) ? ox + ow : nx + nw;
                bottom  = (oy + oh < ny + nh) ? oy + oh : ny + nh;
                overlap = (left < right && top < bottom) ? (right - left) * (bottom - top) : 0;
                merged  = nw * nh + ow * oh - overlap;
                if (merged == 0) begin
                    d.cause  = CAUSE_ZERO_UNION;
                    last_box = b;
                end else if ((overlap << IOU_FRAC_BITS) >= longint'(thr) * merged) begin
                    // older stamps count as no time elapsed
                    elapsed = (b.stamp >= last_box.stamp) ? b.stamp - last_box.stamp : 0;
                    hold_ms = longint'(hold_sec) * MS_PER_SEC;
                    if (elapsed >= hold_ms) begin
                        d.cause  = CAUSE_HOLD_EXP;
                        last_box = b;
                    end else begin
                        d.cause  = CAUSE_SUPPRESSED;
                        d.report = 1'b0;
                    end
                end else begin
                    d.cause  = CAUSE_LOW_OVL;
                    last_box = b;
                end
            end
            pending.push_back(d);
        endfunction

        function void flag(string msg);
            fail_count++;
            if (fail_count <= MAX_REPORTED)
                $display("%0t ns: mismatch: %s", $time, msg);
        endfunction

        function void check_decision(logic report, logic [2:0] cause);
            t_alarm_decision want;
            if (pending.size() == 0) begin
                flag($sformatf("result with no request pending: report %0b cause %0d",
                               report, cause));
                return;
            end
            want = pending.pop_front();
            if (report !== want.report || cause !== want.cause)
                flag($sformatf("expected report %0b cause %0d, got report %0b cause %0d",
                               want.report, want.cause, report, cause));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    ias_cfg_if                                            cfg_bus ();
    ias_box_if #(.COORD_BITS(COORD_W), .STAMP_BITS(STAMP_W)) box_bus ();
    ias_res_if                                            res_bus ();

    iou_alarm_suppressor #(
        .COORD_BITS(COORD_W),
        .STAMP_BITS(STAMP_W)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_box   (box_bus),
        .o_res   (res_bus)
    );

    alarm_scoreboard    sb;
    bit                 calm_phase;     // no idle gaps on either side while set
    logic [STAMP_W-1:0] now_ms;         // running clock for generated stamps

    // ------------------------------------------------------------------------
    // result side: random back-pressure, one stall draw per result
    // ------------------------------------------------------------------------
    initial begin
        int unsigned stall;
        res_bus.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = calm_phase ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                @(negedge i_clk);
                res_bus.ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            res_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!res_bus.valid);
        end
    end

    // every accepted result goes against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && res_bus.valid && res_bus.ready)
            sb.check_decision(res_bus.report, res_bus.cause);
    end

    // ------------------------------------------------------------------------
    // request drivers
    // ------------------------------------------------------------------------

    // one register write request; valid drops on the following falling edge
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do @(posedge i_clk); while (!cfg_bus.ready);
        sb.set_reg(idx, data);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // one box request after a random gap; valid stays high for back-to-back boxes
    task automatic send_box(t_alarm_box b);
        int unsigned gap;
        gap = calm_phase ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            @(negedge i_clk);
            box_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        box_bus.valid      <= 1'b1;
        box_bus.box_x      <= b.x;
        box_bus.box_y      <= b.y;
        box_bus.box_width  <= b.width;
        box_bus.box_height <= b.height;
        box_bus.stamp_ms   <= b.stamp;
        do @(posedge i_clk); while (!box_bus.ready);
        sb.note_box(b);
    endtask

    // stop sending and let every predicted decision come back
    task automatic wait_all_decisions();
        @(negedge i_clk);
        box_bus.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    // registers change only with the block drained
    task automatic set_regs(bit en, logic [THR_BITS-1:0] thr, logic [HOLD_BITS-1:0] hold);
        logic [CFG_DATA_BITS-1:0] en_word;
        wait_all_decisions();
        en_word    = CFG_DATA_BITS'($urandom);  // upper bits are don't-care
        en_word[0] = en;
        write_reg(CFG_ENABLE, en_word);
        write_reg(CFG_THR, CFG_DATA_BITS'(thr));
        write_reg(CFG_HOLD, CFG_DATA_BITS'(hold));
    endtask

    function automatic t_alarm_box mk_box(int unsigned x, int unsigned y, int unsigned w,
                                          int unsigned h, logic [STAMP_W-1:0] t);
        t_alarm_box b;
        b.x      = COORD_W'(x);
        b.y      = COORD_W'(y);
        b.width  = COORD_W'(w);
        b.height = COORD_W'(h);
        b.stamp  = t;
        return b;
    endfunction

    // random box: mostly jittered repeats of the stored box so that the
    // overlap and hold paths get exercised, plus fresh boxes, noise and
    // degenerate sizes; stamps step around the hold boundary
    function automatic t_alarm_box make_alarm();
        t_alarm_box  b;
        t_alarm_box  held;
        int unsigned pick;
        int unsigned hold_ms;
        held    = sb.last_box;
        hold_ms = int'(sb.hold_sec) * MS_PER_SEC;
        pick    = $urandom_range(0, 99);
        if (pick < 60 && (held.width != 0 || held.height != 0)) begin
            b.x      = held.x + COORD_W'($urandom_range(0, 4)) - COORD_W'(2);
            b.y      = held.y + COORD_W'($urandom_range(0, 4)) - COORD_W'(2);
            b.width  = held.width + COORD_W'($urandom_range(0, 4)) - COORD_W'(2);
            b.height = held.height + COORD_W'($urandom_range(0, 4)) - COORD_W'(2);
        end else if (pick < 85) begin
            b.x      = COORD_W'($urandom_range(0, 2000));
            b.y      = COORD_W'($urandom_range(0, 2000));
            b.width  = COORD_W'($urandom_range(1, 300));
            b.height = COORD_W'($urandom_range(1, 300));
        end else if (pick < 95) begin
            b.x      = COORD_W'($urandom);
            b.y      = COORD_W'($urandom);
            b.width  = COORD_W'($urandom);
            b.height = COORD_W'($urandom);
        end else begin
            b.x      = COORD_W'($urandom_range(0, 100));
            b.y      = COORD_W'($urandom_range(0, 100));
            b.width  = $urandom_range(0, 1) ? '0 : COORD_W'($urandom_range(0, 50));
            b.height = $urandom_range(0, 1) ? '0 : COORD_W'($urandom_range(0, 50));
        end

        pick = $urandom_range(0, 99);
        if (pick < 65) begin
            now_ms  = now_ms + STAMP_W'($urandom_range(0, hold_ms * 2 + 20));
            b.stamp = now_ms;
        end else if (pick < 80) begin
            // exactly at the hold limit or one ms short of it
            b.stamp = held.stamp + STAMP_W'(hold_ms) - STAMP_W'($urandom_range(0, 1));
            now_ms  = b.stamp;
        end else if (pick < 92) begin
            // stamp older than the stored one
            b.stamp = held.stamp - STAMP_W'($urandom_range(1, 5000));
        end else begin
            b.stamp = {16'($urandom), 32'($urandom)};
            now_ms  = b.stamp;
        end
        return b;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        int unsigned          sent;
        int unsigned          phase_len;
        bit                   en;
        logic [THR_BITS-1:0]  thr;
        logic [HOLD_BITS-1:0] hold;

        sb                 = new();
        sent               = 0;
        calm_phase         = 1'b0;
        now_ms             = '0;
        i_rst_n            = 1'b0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.index      = '0;
        cfg_bus.data       = '0;
        box_bus.valid      = 1'b0;
        box_bus.box_x      = '0;
        box_bus.box_y      = '0;
        box_bus.box_width  = '0;
        box_bus.box_height = '0;
        box_bus.stamp_ms   = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: history paths with half overlap threshold and 1 s hold
        set_regs(1'b1, THR_BITS'(32768), HOLD_BITS'(1));
        send_box(mk_box(10, 10, 100, 100, 1000));           // empty history
        send_box(mk_box(10, 10, 100, 100, 1500));           // inside hold
        send_box(mk_box(10, 10, 100, 100, 2000));           // hold exactly reached
        send_box(mk_box(10, 10, 100, 100, 500));            // stamp went backwards
        send_box(mk_box(1000, 1000, 50, 50, 3000));         // disjoint box
        send_box(mk_box(65535, 65535, 65535, 65535, '1));   // coordinate extremes
        send_box(mk_box(65535, 65535, 65535, 65535, '0));   // same box, older stamp
        send_box(mk_box(0, 0, 5, 0, 10));                   // flat box is stored
        send_box(mk_box(0, 0, 0, 0, 20));                   // both areas zero
        send_box(mk_box(0, 0, 0, 0, 30));                   // history now empty
        send_box(mk_box(7, 9, 40, 30, 40));

        // full threshold: only an identical box counts as overlapping
        set_regs(1'b1, THR_BITS'(65536), HOLD_BITS'(0));
        send_box(mk_box(7, 9, 40, 30, 50));
        send_box(mk_box(8, 9, 40, 30, 60));

        // threshold above one never matches
        set_regs(1'b1, '1, HOLD_BITS'(0));
        send_box(mk_box(8, 9, 40, 30, 70));

        // zero threshold and disabled suppression both bypass
        set_regs(1'b1, '0, HOLD_BITS'(5));
        send_box(mk_box(8, 9, 40, 30, 80));
        wait_all_decisions();
        write_reg(CFG_SPARE, CFG_DATA_BITS'($urandom));
        set_regs(1'b0, THR_BITS'(32768), HOLD_BITS'(5));
        send_box(mk_box(8, 9, 40, 30, 90));

        // enabling again wipes the history; tiny threshold with a day of hold
        set_regs(1'b1, THR_BITS'(1), HOLD_BITS'(86400));
        send_box(mk_box(100, 100, 10, 10, 5000));
        send_box(mk_box(109, 109, 10, 10, 6000));
        send_box(mk_box(100, 100, 10, 10, 5000 + 86400 * 1000));
        set_regs(1'b1, '1, '1);
        send_box(mk_box(100, 100, 10, 10, 90000000));

        // random phases, each with its own register setting
        while (sent < RANDOM_BOXES) begin
            en = ($urandom_range(0, 9) != 0);
            case ($urandom_range(0, 9))
                0:       thr = '0;
                1:       thr = THR_BITS'(65536);
                2:       thr = '1;
                3:       thr = THR_BITS'($urandom);
                4:       thr = THR_BITS'(1);
                default: thr = THR_BITS'($urandom_range(16384, 60000));
            endcase
            case ($urandom_range(0, 9))
                0:       hold = '0;
                1:       hold = HOLD_BITS'(86400);
                2:       hold = '1;
                3:       hold = HOLD_BITS'($urandom);
                default: hold = HOLD_BITS'($urandom_range(0, 5));
            endcase
            set_regs(en, thr, hold);
            calm_phase = ($urandom_range(0, 4) == 0);
            phase_len  = $urandom_range(20, 80);
            repeat (phase_len) begin
                // now and then hold off until the block has drained
                if ($urandom_range(0, 63) == 0)
                    wait_all_decisions();
                send_box(make_alarm());
                sent++;
            end
        end

        wait_all_decisions();
        repeat (20) @(posedge i_clk);
        if (sb.fail_count == 0)
            $display("iou_alarm_suppressor regression: pass");
        else
            $display("iou_alarm_suppressor regression: fail");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial begin
        #3_000_000;
        $display("iou_alarm_suppressor regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
sv/ias_pkg.sv
sv/ias_box_if.sv
sv/ias_res_if.sv
sv/ias_cfg_if.sv
sv/iou_alarm_suppressor.sv
test/tb_iou_alarm_suppressor.sv
